// File: src/hbv_pkg.sv
// Shared constants, stage types and constant helpers for the Herschel-Bulkley core.
// No dependencies; compiled first.
package hbv_pkg;

   localparam int unsigned LOG_STEPS = 16;
   localparam int unsigned EXP_STEPS = 16;
   localparam int unsigned DIV_STEPS = 32;

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [31:0] MAX_Q16 = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      REG_CONSISTENCY  = 2'd0,
      REG_FLOW_INDEX   = 2'd1,
      REG_YIELD_STRESS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [31:0] cap;
      logic [31:0] rate;
   } carry_type;

   typedef struct packed {
      logic        v;
      carry_type   cr;
      logic [4:0]  b;
      logic [15:0] frac;
      logic [30:0] m;
   } log_stage_type;

   typedef struct packed {
      logic               v;
      carry_type          cr;
      logic               sat;
      logic signed [10:0] ei;
      logic [15:0]        f;
      logic [31:0]        c;
   } exp_stage_type;

   typedef struct packed {
      logic      v;
      carry_type cr;
      logic [48:0] val;
   } arith_stage_type;

   typedef struct packed {
      logic        v;
      logic [31:0] cap;
      logic [31:0] d;
      logic        qsat;
      logic [31:0] rem;
      logic [31:0] low;
      logic [31:0] q;
   } div_stage_type;

   // floor integer square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bw;
      v   = x;
      res = '0;
      bw  = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (bw > v) bw = bw >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (bw != 64'd0) begin
            if (v >= res + bw) begin
               v   = v - (res + bw);
               res = (res >> 1) + bw;
            end else begin
               res = res >> 1;
            end
            bw = bw >> 2;
         end
      end
      return res;
   endfunction

   // 2^(2^-steps) in Q2.30 by repeated truncated roots of 2.0
   function automatic logic [31:0] exp_root(input int unsigned steps);
      logic [63:0] root;
      root = 64'd2 << 30;
      for (int unsigned k = 0; k < steps; k++) begin
         root = isqrt64(root << 30);
      end
      return root[31:0];
   endfunction

   function automatic logic [4:0] msb_pos(input logic [31:0] x);
      logic [4:0] pos;
      pos = '0;
      for (int k = 0; k < 32; k++) begin
         if (x[k]) pos = 5'(k);
      end
      return pos;
   endfunction

endpackage

// File: src/hbv_if.sv
// Valid/ready channel interfaces for the Herschel-Bulkley core.
// Depends on nothing; compiled after hbv_pkg.
interface hbv_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] cap_viscosity;
   logic [31:0] strain_rate;
   modport source (output valid, cap_viscosity, strain_rate, input ready);
   modport sink (input valid, cap_viscosity, strain_rate, output ready);
endinterface

interface hbv_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] viscosity;
   modport source (output valid, viscosity, input ready);
   modport sink (input valid, viscosity, output ready);
endinterface

interface hbv_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: src/herschel_bulkley_viscosity_core.sv
// Herschel-Bulkley apparent viscosity, fully pipelined.
// Depends on hbv_pkg and the channel interfaces in hbv_if.sv.
//
// Usage:
//   req_ch carries one word per cell: cap_viscosity and strain_rate (Q16.16).
//   rsp_ch returns one word per request, in order: viscosity (Q16.16),
//   min(cap, (tau0 + k*rate^n) / max(rate, 1 LSB)).
//   csr_ch writes k (index 0), n (index 1, Q4.12) and tau0 (index 2); it is
//   always ready, other indexes are dropped. Write only while no word is in
//   flight.
// Pipeline:
//   One word accepted per cycle while req_ch.ready is high. From acceptance to
//   rsp valid the stages are: 1 normalize, 16 log2 squaring stages, 1 exponent
//   multiply, 16 exp2 root-multiply stages, 1 shift, 1 k multiply, 1 add,
//   1 divide setup, 32 restoring divide stages (one quotient bit each), 1 output.
// Reset clears the config registers and all valid bits.
// When rsp_ch stalls, one extra word lands in a skid register; only once
// that is full does req_ch.ready drop and the whole pipeline hold.
module herschel_bulkley_viscosity_core
   import hbv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   hbv_req_if.sink      req_ch,
   hbv_rsp_if.source    rsp_ch,
   hbv_csr_if.sink      csr_ch
);

   logic [31:0] consistency_ff;
   logic [15:0] flow_index_ff;
   logic [31:0] yield_stress_ff;

   logic en;

   log_stage_type   lg_ff [0:LOG_STEPS];
   log_stage_type   lg_in [0:LOG_STEPS];
   exp_stage_type   ex_ff [0:EXP_STEPS];
   exp_stage_type   ex_in [0:EXP_STEPS];
   arith_stage_type pw_ff, pw_in;
   arith_stage_type mul_ff, mul_in;
   arith_stage_type num_ff, num_in;
   div_stage_type   dv_ff [0:DIV_STEPS];
   div_stage_type   dv_in [0:DIV_STEPS];

   logic        out_v_ff;
   logic [31:0] out_data_ff;
   logic        sk_v_ff;
   logic [31:0] sk_data_ff;
   logic [31:0] res;

   // ---- config
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         consistency_ff  <= '0;
         flow_index_ff   <= '0;
         yield_stress_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_CONSISTENCY:  consistency_ff  <= csr_ch.data;
            REG_FLOW_INDEX:   flow_index_ff   <= csr_ch.data[15:0];
            REG_YIELD_STRESS: yield_stress_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign en           = !sk_v_ff;
   assign req_ch.ready = en;

   // ---- normalize: mantissa to Q1.30
   always_comb begin
      logic [4:0]  b;
      logic [62:0] sh;
      b  = msb_pos(req_ch.strain_rate);
      sh = {31'b0, req_ch.strain_rate} << (5'd30 - b);
      lg_in[0].v       = req_ch.valid;
      lg_in[0].cr.cap  = req_ch.cap_viscosity;
      lg_in[0].cr.rate = req_ch.strain_rate;
      lg_in[0].b       = b;
      lg_in[0].frac    = '0;
      lg_in[0].m       = (b == 5'd31) ? req_ch.strain_rate[31:1] : sh[30:0];
   end

   // ---- log2 fraction, one squaring per stage
   for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
      always_comb begin
         logic [61:0] sq;
         logic [31:0] t;
         sq = 62'(lg_ff[j].m) * 62'(lg_ff[j].m);
         t  = sq[61:30];
         lg_in[j+1] = lg_ff[j];
         if (t[31]) begin
            lg_in[j+1].frac = {lg_ff[j].frac[14:0], 1'b1};
            lg_in[j+1].m    = t[31:1];
         end else begin
            lg_in[j+1].frac = {lg_ff[j].frac[14:0], 1'b0};
            lg_in[j+1].m    = t[30:0];
         end
      end
   end

   for (genvar j = 0; j <= LOG_STEPS; j++) begin : g_log_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            lg_ff[j].v <= 1'b0;
         end else if (en) begin
            lg_ff[j] <= lg_in[j];
         end
      end
   end

   // ---- exponent E = L * n, split at the binary point
   always_comb begin
      logic signed [5:0]  lint;
      logic signed [21:0] l;
      logic signed [38:0] e;
      lint = $signed({1'b0, lg_ff[LOG_STEPS].b}) - 6'sd16;
      l    = {lint, lg_ff[LOG_STEPS].frac};
      e    = 39'(l) * $signed({23'b0, flow_index_ff});
      ex_in[0].v   = lg_ff[LOG_STEPS].v;
      ex_in[0].cr  = lg_ff[LOG_STEPS].cr;
      ex_in[0].ei  = e[38:28];
      ex_in[0].sat = $signed(e[38:28]) >= 11'sd16;
      ex_in[0].f   = e[27:12];
      ex_in[0].c   = 32'd1 << 30;
   end

   // ---- exp2 of the fraction, one root product per stage
   for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
      localparam logic [31:0] ROOT = exp_root(i + 1);
      always_comb begin
         logic [63:0] pr;
         pr = 64'(ex_ff[i].c) * 64'(ROOT);
         ex_in[i+1] = ex_ff[i];
         if (ex_ff[i].f[EXP_STEPS-1-i]) ex_in[i+1].c = pr[61:30];
      end
   end

   for (genvar i = 0; i <= EXP_STEPS; i++) begin : g_exp_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            ex_ff[i].v <= 1'b0;
         end else if (en) begin
            ex_ff[i] <= ex_in[i];
         end
      end
   end

   // ---- scale to Q16.16 and pick the special cases
   always_comb begin
      logic signed [10:0] s;
      logic [10:0]        neg;
      logic [32:0]        r;
      logic [31:0]        p;
      s   = ex_ff[EXP_STEPS].ei - 11'sd14;
      neg = 11'(-s);
      if (s == 11'sd1) r = {ex_ff[EXP_STEPS].c, 1'b0};
      else if (s == 11'sd0) r = {1'b0, ex_ff[EXP_STEPS].c};
      else if (neg >= 11'd32) r = '0;
      else r = {1'b0, ex_ff[EXP_STEPS].c >> neg[4:0]};
      if (flow_index_ff == 16'd0) p = ONE_Q16;
      else if (ex_ff[EXP_STEPS].cr.rate == 32'd0) p = '0;
      else if (ex_ff[EXP_STEPS].sat || r[32]) p = MAX_Q16;
      else p = r[31:0];
      pw_in.v   = ex_ff[EXP_STEPS].v;
      pw_in.cr  = ex_ff[EXP_STEPS].cr;
      pw_in.val = {17'b0, p};
   end

   // ---- k * p, then + tau0
   always_comb begin
      logic [63:0] kp;
      kp = 64'(consistency_ff) * 64'(pw_ff.val[31:0]);
      mul_in     = pw_ff;
      mul_in.val = {1'b0, kp[63:16]};
      num_in     = mul_ff;
      num_in.val = mul_ff.val + 49'(yield_stress_ff);
   end

   // ---- divide setup: quotient overflow is known from the top bits
   always_comb begin
      logic [31:0] d;
      d = (num_ff.cr.rate == 32'd0) ? 32'd1 : num_ff.cr.rate;
      dv_in[0].v    = num_ff.v;
      dv_in[0].cap  = num_ff.cr.cap;
      dv_in[0].d    = d;
      dv_in[0].qsat = num_ff.val[48] || (num_ff.val[47:16] >= d);
      dv_in[0].rem  = num_ff.val[47:16];
      dv_in[0].low  = {num_ff.val[15:0], 16'b0};
      dv_in[0].q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff.v  <= 1'b0;
         mul_ff.v <= 1'b0;
         num_ff.v <= 1'b0;
      end else if (en) begin
         pw_ff  <= pw_in;
         mul_ff <= mul_in;
         num_ff <= num_in;
      end
   end

   // ---- restoring divide, one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_comb begin
         logic [32:0] r2;
         logic [32:0] diff;
         r2   = {dv_ff[k].rem, dv_ff[k].low[31]};
         diff = r2 - {1'b0, dv_ff[k].d};
         dv_in[k+1]     = dv_ff[k];
         dv_in[k+1].low = {dv_ff[k].low[30:0], 1'b0};
         if (r2 >= {1'b0, dv_ff[k].d}) begin
            dv_in[k+1].rem = diff[31:0];
            dv_in[k+1].q   = {dv_ff[k].q[30:0], 1'b1};
         end else begin
            dv_in[k+1].rem = r2[31:0];
            dv_in[k+1].q   = {dv_ff[k].q[30:0], 1'b0};
         end
      end
   end

   for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k].v <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // ---- cap, then output register with skid
   always_comb begin
      logic [31:0] qv;
      qv  = dv_ff[DIV_STEPS].qsat ? MAX_Q16 : dv_ff[DIV_STEPS].q;
      res = (dv_ff[DIV_STEPS].cap < qv) ? dv_ff[DIV_STEPS].cap : qv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (sk_v_ff) begin
         if (rsp_ch.ready) begin
            out_data_ff <= sk_data_ff;
            sk_v_ff     <= 1'b0;
         end
      end else if (!out_v_ff || rsp_ch.ready) begin
         out_v_ff    <= dv_ff[DIV_STEPS].v;
         out_data_ff <= res;
      end else if (dv_ff[DIV_STEPS].v) begin
         sk_v_ff    <= 1'b1;
         sk_data_ff <= res;
      end
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.viscosity = out_data_ff;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid word held without an output word");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(sk_v_ff) |-> $past(out_v_ff && !rsp_ch.ready))
      else $error("skid filled while output was free");

   a_capped: assert property (@(posedge clock) disable iff (reset)
      dv_ff[DIV_STEPS].v |-> res <= dv_ff[DIV_STEPS].cap)
      else $error("result above cap viscosity");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      dv_ff[DIV_STEPS].v && !dv_ff[DIV_STEPS].qsat
         |-> dv_ff[DIV_STEPS].rem < dv_ff[DIV_STEPS].d)
      else $error("divide remainder not below divisor");
`endif

endmodule

// File: sim/tb_herschel_bulkley_viscosity_core.sv
// Testbench for herschel_bulkley_viscosity_core: directed table plus random cells,
// each result checked against a typed value or an in-bench viscosity predictor.
// Depends on hbv_pkg, the channel interfaces in hbv_if.sv and the core itself.
`timescale 1ns / 1ps

module tb_herschel_bulkley_viscosity_core;
   import hbv_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;   // out-of-range index, write is dropped
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         DRAIN_CYCLES = 100;

   typedef struct {
      logic [31:0] cap;
      logic [31:0] rate;
      bit          typed;
      logic [31:0] visc;
   } cell_row_type;

   typedef struct {
      logic [31:0] k;
      logic [15:0] n;
      logic [31:0] tau0;
   } hb_setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hbv_req_if req_ch ();
   hbv_rsp_if rsp_ch ();
   hbv_csr_if csr_ch ();

   herschel_bulkley_viscosity_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the core's registers
   logic [31:0] k_reg = '0;
   logic [15:0] n_reg = '0;
   logic [31:0] tau0_reg = '0;

   logic [63:0] exp_root_tbl [0:16];
   logic [31:0] visc_expected [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          idle_on = 1'b1;
   int          hold_cycles = 0;

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] trial;
      res = '0;
      for (int bitpos = 31; bitpos >= 0; bitpos--) begin
         trial = res | (64'd1 << bitpos);
         if (trial * trial <= v) res = trial;
      end
      return res;
   endfunction

   function automatic logic [31:0] rate_power(input logic [31:0] rate, input logic [15:0] n);
      int          b;
      logic [63:0] m;
      logic [31:0] frac;
      longint      lg;
      longint      e;
      logic [63:0] eb;
      logic [63:0] e16;
      int          ei;
      logic [15:0] f;
      logic [63:0] c;
      logic [63:0] r;
      int          s;
      b = 31;
      while (!rate[b]) b--;
      m = (b <= 30) ? ({32'd0, rate} << (30 - b)) : ({32'd0, rate} >> 1);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            frac = frac | 32'd1;
            m = m >> 1;
         end
      end
      lg = longint'(b - 16) * 65536 + longint'({32'd0, frac});
      e = lg * longint'({48'd0, n});
      eb = 64'(e + (longint'(256) <<< 28));
      e16 = eb >> 12;
      ei = int'(e16 >> 16) - 256;
      f = e16[15:0];
      if (ei >= 16) return MAX_Q16;
      c = 64'd1 << 30;
      for (int i = 1; i <= 16; i++) begin
         if (f[16 - i]) c = (c * exp_root_tbl[i]) >> 30;
      end
      s = ei - 14;
      if (s >= 0) r = c << s;
      else if (-s >= 64) r = '0;
      else r = c >> (-s);
      if (r > 64'(MAX_Q16)) r = 64'(MAX_Q16);
      return r[31:0];
   endfunction

   function automatic logic [31:0] predict_viscosity(input logic [31:0] cap,
                                                     input logic [31:0] rate);
      logic [31:0] p;
      logic [63:0] num;
      logic [63:0] d;
      logic [63:0] q;
      if (n_reg == 0) p = ONE_Q16;
      else if (rate == 0) p = '0;
      else p = rate_power(rate, n_reg);
      num = ((64'(k_reg) * 64'(p)) >> 16) + 64'(tau0_reg);
      d = (rate == 0) ? 64'd1 : 64'(rate);
      if ((num >> 48) != 0) q = 64'(MAX_Q16);
      else begin
         q = (num << 16) / d;
         if (q > 64'(MAX_Q16)) q = 64'(MAX_Q16);
      end
      if (64'(cap) < q) q = 64'(cap);
      return q[31:0];
   endfunction

   task automatic send_cell(input logic [31:0] cap, input logic [31:0] rate,
                            input bit typed, input logic [31:0] visc);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      visc_expected.push_back(typed ? visc : predict_viscosity(cap, rate));
      req_ch.valid         <= 1'b1;
      req_ch.cap_viscosity <= cap;
      req_ch.strain_rate   <= rate;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (visc_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_CONSISTENCY:  k_reg = data;
         REG_FLOW_INDEX:   n_reg = data[15:0];
         REG_YIELD_STRESS: tau0_reg = data;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input hb_setting_type st);
      write_reg(REG_CONSISTENCY, st.k);
      write_reg(REG_FLOW_INDEX, {16'd0, st.n});
      write_reg(REG_UNUSED, $urandom);
      write_reg(REG_YIELD_STRESS, st.tau0);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_rate();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(1, 3);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [31:0] random_cap();
      case ($urandom_range(0, 5))
         0:       return 32'hFFFF_FFFF;
         1:       return '0;
         2:       return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // receiver: random stall bursts, plus a long hold-off when requested
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall = $urandom_range(1, 13) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (visc_expected.size() == 0) begin
            $error("viscosity: unexpected word, actual %h", rsp_ch.viscosity);
            fail_count++;
         end else begin
            want = visc_expected.pop_front();
            if (rsp_ch.viscosity !== want) begin
               $error("viscosity expected %h actual %h", want, rsp_ch.viscosity);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      cell_row_type   cell_tbl [$];
      hb_setting_type settings [$];
      hb_setting_type st;
      int             per_phase;

      req_ch.valid         = 1'b0;
      req_ch.cap_viscosity = '0;
      req_ch.strain_rate   = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = REG_CONSISTENCY;
      csr_ch.data          = '0;

      exp_root_tbl[0] = 64'd2 << 30;
      for (int i = 1; i <= 16; i++) exp_root_tbl[i] = floor_sqrt(exp_root_tbl[i - 1] << 30);

      // after reset k = n = tau0 = 0, so every cell reads zero
      cell_tbl = '{
         '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0},
         '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0},
         '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0},
         '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0},
         '{32'hFFFF_FFFF, 32'h0001_0000, 1'b1, 32'h0},
         '{32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 32'h0},
         '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 32'h0},
         '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'h0},
         '{32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1, 32'h0},
         '{32'hFFFF_FFFF, 32'h0002_0000, 1'b1, 32'h0},
         '{32'h0001_0000, 32'h0000_8000, 1'b1, 32'h0}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (cell_tbl[i]) send_cell(cell_tbl[i].cap, cell_tbl[i].rate, 1'b1, cell_tbl[i].visc);
      wait_drained();

      // extremes: k max, n zero (rate^0 = 1), divisor floor on zero rate
      st = '{32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF};
      apply_setting(st);
      foreach (cell_tbl[i]) send_cell(cell_tbl[i].cap, cell_tbl[i].rate, 1'b0, '0);
      wait_drained();

      settings = '{
         '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF},
         '{32'h0001_0000, 16'h1000, 32'h0000_0000},
         '{32'h0000_0000, 16'h0001, 32'h0000_0000},
         '{32'h0002_8000, 16'h0800, 32'h0000_4000},
         '{32'hFFFF_FFFF, 16'h3000, 32'h0000_0000},
         '{32'h0000_0001, 16'h0400, 32'hFFFF_FFFF}
      };
      for (int i = 0; i < 2; i++) settings.push_back('{$urandom, 16'($urandom), $urandom});
      per_phase = 1700 / settings.size();

      foreach (settings[ph]) begin
         apply_setting(settings[ph]);
         if (ph == 1) hold_cycles = 400;   // fill the pipe and stall the input
         if (ph == settings.size() - 2) idle_on = 1'b0;
         for (int j = 0; j < per_phase; j++) send_cell(random_cap(), random_rate(), 1'b0, '0);
         wait_drained();
      end

      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// File: herschel_bulkley_viscosity_core.f
src/hbv_pkg.sv
src/hbv_if.sv
src/herschel_bulkley_viscosity_core.sv
sim/tb_herschel_bulkley_viscosity_core.sv
